FILE: sv/qubit_state_vector_engine_defines.svh
// Assertion macros for the state vector engine.
// Used by the top level only; no other dependencies.
`ifndef QUBIT_STATE_VECTOR_ENGINE_DEFINES_SVH
`define QUBIT_STATE_VECTOR_ENGINE_DEFINES_SVH

`define QSVE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define QSVE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/qsve_pkg.sv
// Types and constants for the state vector engine.
// No dependencies.
`timescale 1ns / 1ps
package qsve_pkg;
    localparam int AMP_W  = 18;
    localparam int PROB_W = 33;
    localparam int ACC_W  = 64;
    localparam int GATE_N = 8;

    typedef enum logic [1:0] {
        REQ_RESET = 2'd0,
        REQ_APPLY = 2'd1,
        REQ_READ  = 2'd2,
        REQ_MEAS  = 2'd3
    } t_req;
endpackage

FILE: sv/qsve_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on qsve_pkg.
`timescale 1ns / 1ps
interface qsve_req_if import qsve_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [3:0] target_qubit;
    logic [9:0] amp_index;
    modport source (output valid, req_type, target_qubit, amp_index, input ready);
    modport sink   (input valid, req_type, target_qubit, amp_index, output ready);
endinterface

interface qsve_resp_if import qsve_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        resp_kind;
    logic [AMP_W-1:0]  amp_real;
    logic [AMP_W-1:0]  amp_imag;
    logic [3:0]        qubit_number;
    logic [PROB_W-1:0] zero_prob;
    logic [PROB_W-1:0] one_prob;
    logic              last;
    modport source (output valid, resp_kind, amp_real, amp_imag, qubit_number,
                    zero_prob, one_prob, last, input ready);
    modport sink   (input valid, resp_kind, amp_real, amp_imag, qubit_number,
                    zero_prob, one_prob, last, output ready);
endinterface

interface qsve_cfg_if import qsve_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [2:0]       index;
    logic [AMP_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/qubit_state_vector_engine.sv
// Quantum state vector engine: one block with a shared complex MAC unit.
// Depends on qsve_pkg, qsve_if and qubit_state_vector_engine_defines.svh.
// Sequence: a reset request clears the whole store; an apply gate works through
// each of the 2^(QUBITS-1) pairs in turn (two reads, the sixteen products, two
// writes), or goes straight to its result if the target is not below QUBITS; a read
// passes S_RDA and S_RDB and issues its result itself; a measure takes QUBITS passes,
// two squares per amplitude. Every other request then issues its result in S_RESP,
// and a result waits there until its transfer. The memory with one write and one
// read port and the single 18x18 multiplier set the pace. After reset the store is
// cleared in a pass during which no request is taken.
`timescale 1ns / 1ps
`include "qubit_state_vector_engine_defines.svh"
module qubit_state_vector_engine import qsve_pkg::*; #(
    parameter int QUBITS        = 10,
    parameter int AMP_FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qsve_req_if.sink      i_req,
    qsve_resp_if.source   o_resp,
    qsve_cfg_if.sink      i_cfg
);
    localparam int DEPTH = 1 << QUBITS;
    localparam int QW    = (QUBITS > 1) ? $clog2(QUBITS) : 1;
    localparam int QNW   = QW + 1;
    localparam logic signed [AMP_W-1:0] ONE_V =
        (AMP_FRAC_BITS >= AMP_W - 1) ? AMP_W'(131071) : AMP_W'(1 << AMP_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (AMP_FRAC_BITS - 1));
    localparam logic [ACC_W-1:0] PMAX = {{(ACC_W-PROB_W){1'b0}}, {PROB_W{1'b1}}};

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RDA, S_RDB, S_RDW, S_GA, S_GB, S_GC, S_GMAC, S_GWA,
        S_GWB, S_MRD, S_RESP
    } t_state;

    t_state r_state, r_ret;
    logic [2*AMP_W-1:0] r_mem [DEPTH];
    logic [2*AMP_W-1:0] r_rd;
    logic signed [AMP_W-1:0] r_gate [GATE_N];
    logic [QUBITS:0]    r_cnt;
    logic [QUBITS-1:0]  r_addr;
    logic [QNW-1:0]     r_q;
    logic [1:0]         r_kind;
    logic signed [AMP_W-1:0] r_ar, r_ai, r_br, r_bi;
    logic signed [ACC_W-1:0] r_acc;
    logic [3:0]         r_step;
    logic signed [AMP_W-1:0] r_n0r, r_n0i, r_n1r;
    logic signed [2*AMP_W-1:0] r_prod;
    logic [ACC_W-1:0]   r_z, r_o;
    logic               r_pv;
    logic               r_mv;
    logic               msub_d;
    logic [QUBITS-1:0]  r_maddr;

    logic               we;
    logic [QUBITS-1:0]  wa, ra;
    logic [2*AMP_W-1:0] wd;
    logic signed [AMP_W-1:0] ma, mb;
    logic               msub;
    logic signed [ACC_W-1:0] rnd;
    logic signed [AMP_W-1:0] sat;
    logic [QUBITS-1:0]  bitm, lo_mask, pidx;

    assign i_req.ready = (r_state == S_IDLE) && !o_resp.valid;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate[0] <= AMP_W'(65536);
            r_gate[1] <= '0; r_gate[2] <= '0; r_gate[3] <= '0;
            r_gate[4] <= '0; r_gate[5] <= '0;
            r_gate[6] <= AMP_W'(65536);
            r_gate[7] <= '0;
        end else if (i_cfg.valid) begin
            r_gate[i_cfg.index] <= i_cfg.data;
        end
    end

    // pair index: insert a zero at the target bit of the pair counter
    always_comb begin
        bitm    = QUBITS'(1) << r_q[QW-1:0];
        lo_mask = bitm - QUBITS'(1);
        pidx    = (((r_cnt[QUBITS-1:0] & ~lo_mask) << 1) | (r_cnt[QUBITS-1:0] & lo_mask));
    end

    // shared multiplier operands: 16 product terms over four outputs, or squares while measuring
    always_comb begin
        ma = '0; mb = '0; msub = 1'b0;
        case (r_step[1:0])
            2'd0: ma = r_ar;
            2'd1: ma = r_ai;
            2'd2: ma = r_br;
            default: ma = r_bi;
        endcase
        case (r_step)
            4'd0: mb = r_gate[0];
            4'd1: begin mb = r_gate[1]; msub = 1'b1; end
            4'd2: mb = r_gate[2];
            4'd3: begin mb = r_gate[3]; msub = 1'b1; end
            4'd4: mb = r_gate[1];
            4'd5: mb = r_gate[0];
            4'd6: mb = r_gate[3];
            4'd7: mb = r_gate[2];
            4'd8: mb = r_gate[4];
            4'd9: begin mb = r_gate[5]; msub = 1'b1; end
            4'd10: mb = r_gate[6];
            4'd11: begin mb = r_gate[7]; msub = 1'b1; end
            4'd12: mb = r_gate[5];
            4'd13: mb = r_gate[4];
            4'd14: mb = r_gate[7];
            default: mb = r_gate[6];
        endcase
        if (r_state == S_MRD) begin
            ma = r_step[0] ? $signed(r_rd[2*AMP_W-1:AMP_W]) : $signed(r_rd[AMP_W-1:0]);
            mb = ma;
        end
    end

    always_comb begin
        rnd = (r_acc + HALF) >>> AMP_FRAC_BITS;
        if (rnd > ACC_W'(131071)) sat = AMP_W'(131071);
        else if (rnd < -ACC_W'(131072)) sat = -AMP_W'(131072);
        else sat = rnd[AMP_W-1:0];
    end

    always_comb begin
        we = 1'b0; wa = r_addr; wd = '0; ra = r_addr;
        case (r_state)
            S_CLR: begin
                we = 1'b1; wa = r_cnt[QUBITS-1:0];
                wd = (r_cnt == '0) ? {ONE_V, {AMP_W{1'b0}}} : '0;
            end
            S_GWA: begin we = 1'b1; wa = pidx; wd = {r_n0r, r_n0i}; end
            S_GWB: begin we = 1'b1; wa = pidx | bitm; wd = {r_n1r, sat}; end
            S_GA:  ra = pidx;
            S_GB:  ra = pidx | bitm;
            S_MRD: ra = r_cnt[QUBITS-1:0];
            default: ra = r_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret <= S_IDLE;
            r_cnt <= '0;
            r_pv <= 1'b0;
            r_mv <= 1'b0;
            o_resp.valid <= 1'b0;
        end else begin
            if (o_resp.valid && o_resp.ready) o_resp.valid <= 1'b0;
            r_prod <= ma * mb;
            case (r_state)
                S_CLR: begin
                    if (r_cnt[QUBITS-1:0] == QUBITS'(DEPTH-1)) begin
                        r_cnt <= '0;
                        r_state <= r_ret;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: if (i_req.valid && !o_resp.valid) begin
                    r_kind <= i_req.req_type;
                    r_addr <= i_req.amp_index[QUBITS-1:0];
                    r_cnt <= '0;
                    case (t_req'(i_req.req_type))
                        REQ_RESET: begin
                            r_q <= '0; r_ret <= S_RESP; r_state <= S_CLR;
                        end
                        REQ_APPLY: begin
                            r_q <= QNW'(i_req.target_qubit);
                            r_state <= (int'(i_req.target_qubit) < QUBITS) ? S_GA : S_RESP;
                        end
                        REQ_READ: begin r_q <= '0; r_state <= S_RDA; end
                        default: begin
                            r_q <= '0;
                            r_z <= '0; r_o <= '0; r_mv <= 1'b0; r_step <= '0;
                            r_state <= S_MRD;
                        end
                    endcase
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    o_resp.resp_kind <= r_kind;
                    o_resp.amp_real <= r_rd[2*AMP_W-1:AMP_W];
                    o_resp.amp_imag <= r_rd[AMP_W-1:0];
                    o_resp.qubit_number <= '0;
                    o_resp.zero_prob <= '0; o_resp.one_prob <= '0;
                    o_resp.last <= 1'b1; o_resp.valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_GA: r_state <= S_GB;
                S_GB: begin
                    r_ar <= r_rd[2*AMP_W-1:AMP_W]; r_ai <= r_rd[AMP_W-1:0];
                    r_state <= S_GC;
                end
                S_GC: begin
                    r_br <= r_rd[2*AMP_W-1:AMP_W]; r_bi <= r_rd[AMP_W-1:0];
                    r_step <= '0; r_acc <= '0;
                    r_state <= S_GMAC;
                end
                S_GMAC: begin
                    // one product per cycle, registered in r_prod and accumulated in the next cycle
                    msub_d <= msub;
                    if (r_pv && r_step[1:0] == 2'd1 && r_step != 4'd1) begin
                        case (r_step[3:2])
                            2'd1: r_n0r <= sat;
                            2'd2: r_n0i <= sat;
                            default: r_n1r <= sat;
                        endcase
                        r_acc <= msub_d ? -ACC_W'(r_prod) : ACC_W'(r_prod);
                    end else if (r_pv) begin
                        r_acc <= msub_d ? r_acc - ACC_W'(r_prod)
                                        : r_acc + ACC_W'(r_prod);
                    end
                    if (r_pv && r_step == 4'd0) begin
                        r_pv <= 1'b0;
                        r_state <= S_GWA;
                    end else begin
                        r_pv <= 1'b1;
                        r_step <= r_step + 1'b1;
                    end
                end
                S_GWA: r_state <= S_GWB;
                S_GWB: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[QUBITS-1:0] == QUBITS'(DEPTH/2-1)) r_state <= S_RESP;
                    else r_state <= S_GA;
                end
                S_MRD: begin
                    // stream: read, square re then im, accumulate
                    r_step <= r_step + 1'b1;
                    r_mv <= r_step[0] ? (r_cnt != (QUBITS+1)'(DEPTH)) : (r_cnt != '0);
                    if (r_mv) begin
                        if (r_maddr[r_q[QW-1:0]]) r_o <= r_o + ACC_W'(r_prod);
                        else r_z <= r_z + ACC_W'(r_prod);
                    end
                    if (r_step[0]) begin
                        r_maddr <= r_cnt[QUBITS-1:0];
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_step[0] && r_cnt == (QUBITS+1)'(DEPTH)) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: if (!o_resp.valid) begin
                    o_resp.resp_kind <= r_kind;
                    o_resp.amp_real <= '0; o_resp.amp_imag <= '0;
                    o_resp.valid <= 1'b1;
                    if (r_kind == REQ_MEAS) begin
                        o_resp.qubit_number <= 4'(r_q);
                        o_resp.zero_prob <= (r_z > PMAX) ? PMAX[PROB_W-1:0] : r_z[PROB_W-1:0];
                        o_resp.one_prob <= (r_o > PMAX) ? PMAX[PROB_W-1:0] : r_o[PROB_W-1:0];
                        o_resp.last <= (r_q == QNW'(QUBITS-1));
                        if (r_q != QNW'(QUBITS-1)) begin
                            r_q <= r_q + 1'b1;
                            r_cnt <= '0; r_z <= '0; r_o <= '0;
                            r_step <= '0; r_mv <= 1'b0;
                            r_state <= S_MRD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        o_resp.qubit_number <= '0;
                        o_resp.zero_prob <= '0; o_resp.one_prob <= '0;
                        o_resp.last <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `QSVE_ASSERT_IMPL(a_busy_not_ready, i_clk, i_rst_n,
        r_state != S_IDLE, !i_req.ready, "request taken while busy")
    `QSVE_ASSERT_NEXT(a_clear_then_idle, i_clk, i_rst_n,
        i_req.valid && i_req.ready, r_state != S_IDLE, "request not started")
endmodule
